// File: src/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared constants, codes and control structs of the first-fit block
// allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffba_pkg;

    localparam int POOL_BLOCKS = 64;
    localparam int IDX_W       = $clog2(POOL_BLOCKS);

    localparam int FUNC_W   = 2;
    localparam int COUNT_W  = 7;
    localparam int HKIND_W  = 2;
    localparam int HIDX_W   = 6;
    localparam int STATUS_W = 3;
    localparam int START_W  = 6;
    localparam int KIND_W   = 2;
    localparam int ENTRY_W  = COUNT_W + KIND_W;

    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    localparam logic [HKIND_W-1:0] HK_NULL = 2'd0;
    localparam logic [HKIND_W-1:0] HK_POOL = 2'd2;

    localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SINGLE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FIRST  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TRAIL  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_INPUT = 3'd1;
    localparam logic [STATUS_W-1:0] ST_IN_POOL   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
    localparam logic [STATUS_W-1:0] ST_TRAILING  = 3'd5;

    typedef struct packed {
        logic                load;
        logic                scan_step;
        logic                fill_step;
        logic                rel_start;
        logic                rel_step;
        logic                clear_all;
        logic                push;
        logic [STATUS_W-1:0] status;
        logic                start_sel;
    } ffba_cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              count_zero;
        logic              h_null;
        logic              h_in_pool;
        logic              scan_hit;
        logic              scan_last;
        logic              kind_head;
        logic              walk_last;
        logic              out_free;
    } ffba_stat_t;

endpackage

`default_nettype wire

// File: src/ffba_ram.sv
// ----------------------------------------------------------------------------
// ffba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// File: src/ffba_ctrl.sv
// ----------------------------------------------------------------------------
// ffba_ctrl
// Request sequencer: decode, first-fit scan, run fill, run release and
// result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ffba_pkg::ffba_stat_t stat,
    output ffba_pkg::ffba_cmd_t  cmd
);

    import ffba_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_DECODE  = 3'd1;
    localparam logic [2:0] S_SCAN    = 3'd2;
    localparam logic [2:0] S_FILL    = 3'd3;
    localparam logic [2:0] S_CHECK   = 3'd4;
    localparam logic [2:0] S_RELEASE = 3'd5;
    localparam logic [2:0] S_DONE    = 3'd6;

    logic [2:0]          state_reg, state_next;
    logic [STATUS_W-1:0] code_reg, code_next;
    logic                sel_reg, sel_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        sel_next   = sel_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                sel_next = 1'b0;
                case (stat.func)
                    FUNC_ALLOC:
                    begin
                        if (stat.count_zero)
                        begin
                            code_next  = ST_BAD_INPUT;
                            state_next = S_DONE;
                        end
                        else if (stat.h_in_pool)
                        begin
                            code_next  = ST_IN_POOL;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    FUNC_FREE:
                    begin
                        if (stat.h_null)
                        begin
                            code_next  = ST_BAD_INPUT;
                            state_next = S_DONE;
                        end
                        else if (!stat.h_in_pool)
                        begin
                            code_next  = ST_NOT_FOUND;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_CHECK;
                        end
                    end
                    FUNC_CLEAR:
                    begin
                        cmd.clear_all = 1'b1;
                        code_next     = ST_OK;
                        state_next    = S_DONE;
                    end
                    default:
                    begin
                        code_next  = ST_BAD_INPUT;
                        state_next = S_DONE;
                    end
                endcase
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_hit)
                begin
                    state_next = S_FILL;
                end
                else if (stat.scan_last)
                begin
                    code_next  = ST_NO_SPACE;
                    state_next = S_DONE;
                end
            end
            S_FILL:
            begin
                cmd.fill_step = 1'b1;
                if (stat.walk_last)
                begin
                    code_next  = ST_OK;
                    sel_next   = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_CHECK:
            begin
                if (stat.kind_head)
                begin
                    cmd.rel_start = 1'b1;
                    state_next    = S_RELEASE;
                end
                else
                begin
                    code_next  = ST_TRAILING;
                    state_next = S_DONE;
                end
            end
            S_RELEASE:
            begin
                cmd.rel_step = 1'b1;
                if (stat.walk_last)
                begin
                    code_next  = ST_OK;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.push      = 1'b1;
                    cmd.status    = code_reg;
                    cmd.start_sel = sel_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            code_reg  <= ST_OK;
            sel_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
            sel_reg   <= sel_next;
        end
    end

endmodule

`default_nettype wire

// File: src/ffba_dp.sv
// ----------------------------------------------------------------------------
// ffba_dp
// Datapath: request word, scan and walk counters, occupancy bits, entry
// RAM and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [ffba_pkg::FUNC_W-1:0]    func,
    input  logic [ffba_pkg::COUNT_W-1:0]   block_count,
    input  logic [ffba_pkg::HKIND_W-1:0]   handle_kind,
    input  logic [ffba_pkg::HIDX_W-1:0]    handle_index,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic [ffba_pkg::STATUS_W-1:0]  status,
    output logic [ffba_pkg::START_W-1:0]   start_index,
    input  ffba_pkg::ffba_cmd_t            cmd,
    output ffba_pkg::ffba_stat_t           stat
);

    import ffba_pkg::*;

    logic [FUNC_W-1:0]      func_reg, func_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [HKIND_W-1:0]     hkind_reg, hkind_next;
    logic [HIDX_W-1:0]      hidx_reg, hidx_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [COUNT_W-1:0]     run_reg, run_next;
    logic [IDX_W-1:0]       first_reg, first_next;
    logic [IDX_W-1:0]       ptr_reg, ptr_next;
    logic [COUNT_W-1:0]     left_reg, left_next;
    logic [POOL_BLOCKS-1:0] valid_reg, valid_next;
    logic                   out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic [START_W-1:0]     start_reg, start_next;

    logic [IDX_W-1:0]       pos;
    logic [COUNT_W-1:0]     run_inc;
    logic                   entry_free;
    logic [KIND_W-1:0]      fill_kind;
    logic [KIND_W-1:0]      kind_eff;
    logic [ENTRY_W-1:0]     rd_data;

    assign pos        = IDX_W'(hidx_reg);
    assign run_inc    = run_reg + COUNT_W'(1);
    assign entry_free = !valid_reg[idx_reg];

    always_comb
    begin
        if (ptr_reg == first_reg)
        begin
            fill_kind = (count_reg == COUNT_W'(1)) ? KIND_SINGLE : KIND_FIRST;
        end
        else
        begin
            fill_kind = KIND_TRAIL;
        end
    end

    // entries without an occupancy bit read as empty
    assign kind_eff = valid_reg[pos] ? rd_data[KIND_W-1:0] : KIND_EMPTY;

    ffba_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (POOL_BLOCKS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (cmd.fill_step),
        .wr_addr (ptr_reg),
        .wr_data ({count_reg, fill_kind}),
        .rd_addr (pos),
        .rd_data (rd_data)
    );

    always_comb
    begin
        stat.func       = func_reg;
        stat.count_zero = (count_reg == '0);
        stat.h_null     = (hkind_reg == HK_NULL);
        stat.h_in_pool  = (hkind_reg == HK_POOL) && (32'(hidx_reg) < 32'(POOL_BLOCKS));
        stat.scan_hit   = entry_free && (run_inc == count_reg);
        stat.scan_last  = (idx_reg == IDX_W'(POOL_BLOCKS - 1));
        stat.kind_head  = kind_eff inside {KIND_SINGLE, KIND_FIRST};
        stat.walk_last  = (left_reg == COUNT_W'(1)) || (ptr_reg == IDX_W'(POOL_BLOCKS - 1));
        stat.out_free   = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        func_next      = func_reg;
        count_next     = count_reg;
        hkind_next     = hkind_reg;
        hidx_next      = hidx_reg;
        idx_next       = idx_reg;
        run_next       = run_reg;
        first_next     = first_reg;
        ptr_next       = ptr_reg;
        left_next      = left_reg;
        valid_next     = valid_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        start_next     = start_reg;

        if (cmd.load)
        begin
            func_next  = func;
            count_next = block_count;
            hkind_next = handle_kind;
            hidx_next  = handle_index;
            idx_next   = '0;
            run_next   = '0;
        end

        if (cmd.scan_step)
        begin
            idx_next = idx_reg + IDX_W'(1);
            if (entry_free)
            begin
                run_next = run_inc;
                if (run_reg == '0)
                begin
                    first_next = idx_reg;
                end
            end
            else
            begin
                run_next = '0;
            end
            if (stat.scan_hit)
            begin
                ptr_next  = (run_reg == '0) ? idx_reg : first_reg;
                left_next = count_reg;
            end
        end

        if (cmd.fill_step)
        begin
            valid_next[ptr_reg] = 1'b1;
            ptr_next            = ptr_reg + IDX_W'(1);
            left_next           = left_reg - COUNT_W'(1);
        end

        if (cmd.rel_start)
        begin
            ptr_next  = pos;
            left_next = rd_data[ENTRY_W-1:KIND_W];
        end

        if (cmd.rel_step)
        begin
            valid_next[ptr_reg] = 1'b0;
            ptr_next            = ptr_reg + IDX_W'(1);
            left_next           = left_reg - COUNT_W'(1);
        end

        if (cmd.clear_all)
        begin
            valid_next = '0;
        end

        if (cmd.push)
        begin
            out_valid_next = 1'b1;
            status_next    = cmd.status;
            start_next     = cmd.start_sel ? START_W'(first_reg) : '0;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        count_reg  <= count_next;
        hkind_reg  <= hkind_next;
        hidx_reg   <= hidx_next;
        idx_reg    <= idx_next;
        run_reg    <= run_next;
        first_reg  <= first_next;
        ptr_reg    <= ptr_next;
        left_reg   <= left_next;
        status_reg <= status_next;
        start_reg  <= start_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign start_index = start_reg;

endmodule

`default_nettype wire

// File: src/first_fit_block_allocator_top.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator_top
// First-fit contiguous block allocator over a status table of pool blocks.
// ----------------------------------------------------------------------------
// rejected or clear words go from decode straight to the result; allocate scans
//   the pool one block per scan step, then fills one RAM entry per block
// free: checks the head entry, then releases one block per step
// one word in flight; a new word is taken while the last result waits
// reset: asynchronous, empties the table at once through per-block occupancy bits
`default_nettype none

module first_fit_block_allocator_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ffba_pkg::FUNC_W-1:0]   func,
    input  logic [ffba_pkg::COUNT_W-1:0]  block_count,
    input  logic [ffba_pkg::HKIND_W-1:0]  handle_kind,
    input  logic [ffba_pkg::HIDX_W-1:0]   handle_index,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ffba_pkg::STATUS_W-1:0] status,
    output logic [ffba_pkg::START_W-1:0]  start_index
);

    import ffba_pkg::*;

    ffba_cmd_t  cmd;
    ffba_stat_t stat;

    ffba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ffba_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .func         (func),
        .block_count  (block_count),
        .handle_kind  (handle_kind),
        .handle_index (handle_index),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .status       (status),
        .start_index  (start_index),
        .cmd          (cmd),
        .stat         (stat)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken again before result");

    a_push_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> !in_ready)
        else $error("result pushed while idle");

    a_start_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.push && cmd.start_sel) |-> (cmd.status == ST_OK))
        else $error("start index given with error status");

    a_push_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.push && out_valid) |-> out_ready)
        else $error("result overwritten");
`endif

endmodule

`default_nettype wire
